[hw/rtl/plpt_pkg.sv]
// ----------------------------------------------------------------------------
// plpt_pkg
// Shared types and constants for the piecewise-linear profile table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package plpt_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Q2.14 one, Q16.16 defaults for an empty table
    localparam logic signed [POS_W-1:0]   POS_ONE     = 16'sd16384;
    localparam logic signed [POS_W-1:0]   POS_NEG_ONE = -16'sd16384;
    localparam logic signed [VALUE_W-1:0] NEG_ONE_Q16 = -32'sd65536;
    localparam logic signed [VALUE_W-1:0] NEG_PI_Q16  = -32'sd205887;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_prod;
    } lane_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/plpt_cmd_if.sv]
// ----------------------------------------------------------------------------
// plpt_cmd_if
// Command channel: clear, append point, or query at a position.
// ----------------------------------------------------------------------------
`default_nettype none

interface plpt_cmd_if;
    import plpt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] point_x;
    logic signed [VALUE_W-1:0] point_y;
    logic signed [VALUE_W-1:0] point_lateral;
    logic signed [VALUE_W-1:0] point_roll;
    logic signed [POS_W-1:0]   position;

    modport source (
        output valid, command, point_x, point_y, point_lateral, point_roll, position,
        input  ready
    );

    modport sink (
        input  valid, command, point_x, point_y, point_lateral, point_roll, position,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/plpt_rsp_if.sv]
// ----------------------------------------------------------------------------
// plpt_rsp_if
// Response channel: interpolated profile point and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface plpt_rsp_if;
    import plpt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_x;
    logic signed [VALUE_W-1:0] out_y;
    logic signed [VALUE_W-1:0] out_lateral;
    logic signed [VALUE_W-1:0] out_roll;
    logic                      table_empty;
    logic                      overflowed;

    modport source (
        output valid, out_x, out_y, out_lateral, out_roll, table_empty, overflowed,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_lateral, out_roll, table_empty, overflowed,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/plpt_lerp_lane.sv]
// ----------------------------------------------------------------------------
// plpt_lerp_lane
// One interpolation lane: a + floor((b - a) * frac / 2^FRACTION_BITS).
// ----------------------------------------------------------------------------
`default_nettype none

module plpt_lerp_lane #(
    parameter int FRACTION_BITS = 15
) (
    input  wire                              clk,
    input  wire plpt_pkg::lane_ctrl_t        ctrl,
    input  wire logic [plpt_pkg::VALUE_W-1:0] data,
    input  wire logic [FRACTION_BITS:0]      frac,
    output logic [plpt_pkg::VALUE_W-1:0]     result
);
    import plpt_pkg::*;

    localparam int DW = VALUE_W + 1;
    localparam int PW = DW + FRACTION_BITS + 2;

    logic signed [VALUE_W-1:0] a_reg;
    logic signed [DW-1:0]      diff_reg;
    logic signed [DW-1:0]      diff_next;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      prod_next;
    logic signed [PW-1:0]      shifted;

    always_comb
    begin
        diff_next = $signed({data[VALUE_W-1], data}) - $signed({a_reg[VALUE_W-1], a_reg});
        prod_next = diff_reg * $signed({1'b0, frac});
        shifted   = prod_reg >>> FRACTION_BITS;
        result    = a_reg + shifted[VALUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            a_reg <= data;
        end
        if (ctrl.load_b)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/piecewise_linear_profile_table_unit.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_profile_table_unit
// Profile point table in a single-port memory with linear interpolation.
// ----------------------------------------------------------------------------
// Clear and append are done at accept, in the idle state; cmd.ready stays high after them.
// A query loads its response after these steps from accept: index and fraction,
// first read, second read and difference, multiply, sum; the sum waits while the response register is full.
// One item is in work at a time; the response register frees the input side.
// Reset empties the table and clears the overflow flag; no clearing pass.
`default_nettype none

module piecewise_linear_profile_table_unit #(
    parameter int TABLE_DEPTH   = 64,
    parameter int FRACTION_BITS = 15
) (
    input  wire         clk,
    input  wire         rst_n,
    plpt_cmd_if.sink    cmd,
    plpt_rsp_if.source  rsp
);
    import plpt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = POS_W + CW;
    localparam int FW = FRACTION_BITS;
    localparam int MW = 4 * VALUE_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [FW:0]   FRAC_ONE = {1'b1, {FW{1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;

    logic [TW-1:0]             t_reg, t_next;
    logic [CW-1:0]             seg_reg, seg_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic                      empty_reg, empty_next;
    logic                      single_reg, single_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [FW:0]               frac_reg, frac_next;

    logic [MW-1:0]  mem [TABLE_DEPTH];
    logic [MW-1:0]  q_reg;
    logic [MW-1:0]  mem_wdata;
    logic [AW-1:0]  mem_addr;
    logic           mem_we;

    logic                      accept;
    logic                      load_out;
    logic [POS_W-1:0]          u;
    logic [CW:0]               idx_raw;
    logic [CW-1:0]             seg_m1;
    logic [FW+14:0]            frac_wide;
    logic                      top_end;
    lane_ctrl_t                lane_ctrl;
    logic [VALUE_W-1:0]        lane_res [4];

    logic signed [VALUE_W-1:0] out_x_reg, out_y_reg, out_lat_reg, out_roll_reg;
    logic                      out_empty_reg, out_ovf_reg;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // segment mapping
    always_comb
    begin
        pos_next = cmd.position;
        if (cmd.position < POS_NEG_ONE)
        begin
            pos_next = POS_NEG_ONE;
        end
        else if (cmd.position > POS_ONE)
        begin
            pos_next = POS_ONE;
        end
        u           = POS_W'(pos_next + POS_ONE);
        empty_next  = (count_reg == '0);
        single_next = (count_reg == CW'(1));
        seg_next    = (empty_next || single_next) ? CW'(1) : count_reg - CW'(1);
        t_next      = (empty_next || single_next) ? '0
                    : {{CW{1'b0}}, u} * {{POS_W{1'b0}}, seg_next};

        idx_raw   = t_reg[TW-1:15];
        seg_m1    = seg_reg - CW'(1);
        frac_wide = {t_reg[14:0], {FW{1'b0}}};
        top_end   = (idx_raw >= {1'b0, seg_reg});
        idx_next  = top_end ? seg_m1[AW-1:0] : idx_raw[AW-1:0];
        frac_next = top_end ? FRAC_ONE : {1'b0, frac_wide[FW+14:15]};
    end

    // sequencer and memory port
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        mem_we     = 1'b0;
        mem_addr   = idx_reg;
        mem_wdata  = {cmd.point_roll, cmd.point_lateral, cmd.point_y, cmd.point_x};
        lane_ctrl  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                mem_addr = count_reg[AW-1:0];
                if (accept)
                begin
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_ADDR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADDR:
            begin
                mem_addr   = idx_next;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                mem_addr         = idx_reg + AW'(1);
                lane_ctrl.load_a = 1'b1;
                state_next       = ST_RD2;
            end
            ST_RD2:
            begin
                lane_ctrl.load_b = 1'b1;
                state_next       = ST_MUL;
            end
            ST_MUL:
            begin
                lane_ctrl.load_prod = 1'b1;
                state_next          = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            q_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg      <= t_next;
            seg_reg    <= seg_next;
            pos_reg    <= pos_next;
            empty_reg  <= empty_next;
            single_reg <= single_next;
        end
        if (state_reg == ST_ADDR)
        begin
            idx_reg  <= idx_next;
            frac_reg <= frac_next;
        end
        if (load_out)
        begin
            out_empty_reg <= empty_reg;
            out_ovf_reg   <= ovf_reg;
            if (empty_reg)
            begin
                out_x_reg    <= NEG_ONE_Q16;
                out_y_reg    <= NEG_ONE_Q16;
                out_lat_reg  <= {{14{pos_reg[POS_W-1]}}, pos_reg, 2'b00};
                out_roll_reg <= NEG_PI_Q16;
            end
            else if (single_reg)
            begin
                out_x_reg    <= q_reg[VALUE_W-1:0];
                out_y_reg    <= q_reg[2*VALUE_W-1:VALUE_W];
                out_lat_reg  <= q_reg[3*VALUE_W-1:2*VALUE_W];
                out_roll_reg <= q_reg[4*VALUE_W-1:3*VALUE_W];
            end
            else
            begin
                out_x_reg    <= lane_res[0];
                out_y_reg    <= lane_res[1];
                out_lat_reg  <= lane_res[2];
                out_roll_reg <= lane_res[3];
            end
        end
    end

    // single point: q_reg holds entry zero again by the response, read back from idx_reg
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        plpt_lerp_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .data   (q_reg[i*VALUE_W +: VALUE_W]),
            .frac   (frac_reg),
            .result (lane_res[i])
        );
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_x       = out_x_reg;
    assign rsp.out_y       = out_y_reg;
    assign rsp.out_lateral = out_lat_reg;
    assign rsp.out_roll    = out_roll_reg;
    assign rsp.table_empty = out_empty_reg;
    assign rsp.overflowed  = out_ovf_reg;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise-linear profile table unit.
// Clear, append, query and unused items go in with random gaps on both channels. A
// scoreboard keeps its own copy of the profile table, predicts every query
// and compares each returned point and its flags in order.
// ----------------------------------------------------------------------------
module tb;
    import plpt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int FRAC_BITS    = 15;
    localparam int ITEM_TARGET  = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] y;
        logic signed [VALUE_W-1:0] lateral;
        logic signed [VALUE_W-1:0] roll;
    } profile_point_t;

    typedef struct {
        logic [CMD_W-1:0]        command;
        profile_point_t          pt;
        logic signed [POS_W-1:0] position;
    } cmd_item_t;

    typedef struct {
        profile_point_t pt;
        logic           table_empty;
        logic           overflowed;
    } query_result_t;

    class profile_scoreboard;
        profile_point_t points[DEPTH];
        int unsigned    point_count;
        bit             overflow_seen;
        query_result_t  expected_q[$];
        int             mismatches;

        function new();
            point_count   = 0;
            overflow_seen = 0;
            mismatches    = 0;
        endfunction

        // a + floor((b - a) * frac / 2^FRAC_BITS)
        function logic signed [VALUE_W-1:0] blend(input logic signed [VALUE_W-1:0] a,
                                                  input logic signed [VALUE_W-1:0] b,
                                                  input longint frac);
            longint prod;
            prod = (longint'(b) - longint'(a)) * frac;
            return 32'(longint'(a) + (prod >>> FRAC_BITS));
        endfunction

        function query_result_t lookup(input logic signed [POS_W-1:0] position);
            longint        p;
            longint        segs;
            longint        t;
            longint        idx;
            longint        frac;
            query_result_t r;
            p = longint'(position);
            if (p < longint'(POS_NEG_ONE))
                p = longint'(POS_NEG_ONE);
            if (p > longint'(POS_ONE))
                p = longint'(POS_ONE);
            r.table_empty = 1'b0;
            r.overflowed  = overflow_seen;
            if (point_count == 0)
            begin
                r.pt.x        = NEG_ONE_Q16;
                r.pt.y        = NEG_ONE_Q16;
                r.pt.lateral  = 32'(p * 4);
                r.pt.roll     = NEG_PI_Q16;
                r.table_empty = 1'b1;
            end
            else if (point_count == 1)
            begin
                r.pt = points[0];
            end
            else
            begin
                segs = longint'(point_count) - 1;
                t    = (p + longint'(POS_ONE)) * segs;
                idx  = t >> 15;
                frac = ((t & 'h7FFF) << FRAC_BITS) >> 15;
                // top end: step back one segment, full fraction
                if (idx >= segs)
                begin
                    idx  = segs - 1;
                    frac = longint'(1) << FRAC_BITS;
                end
                r.pt.x       = blend(points[idx].x, points[idx+1].x, frac);
                r.pt.y       = blend(points[idx].y, points[idx+1].y, frac);
                r.pt.lateral = blend(points[idx].lateral, points[idx+1].lateral, frac);
                r.pt.roll    = blend(points[idx].roll, points[idx+1].roll, frac);
            end
            return r;
        endfunction

        function void note_command(input cmd_item_t it);
            case (it.command)
                CMD_CLEAR:
                    point_count = 0;
                CMD_APPEND:
                begin
                    if (point_count >= DEPTH)
                        overflow_seen = 1'b1;
                    else
                    begin
                        points[point_count] = it.pt;
                        point_count++;
                    end
                end
                CMD_QUERY:
                    expected_q.insert(expected_q.size(), lookup(it.position));
                default:
                    ;
            endcase
        endfunction

        function void check_point(input query_result_t got);
            query_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: x=%h y=%h lat=%h roll=%h empty=%b ovf=%b",
                             got.pt.x, got.pt.y, got.pt.lateral, got.pt.roll,
                             got.table_empty, got.overflowed);
                return;
            end
            want = expected_q.pop_front();
            if (got.pt !== want.pt || got.table_empty !== want.table_empty ||
                got.overflowed !== want.overflowed)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: exp x=%h y=%h lat=%h roll=%h empty=%b ovf=%b",
                             $realtime, want.pt.x, want.pt.y, want.pt.lateral, want.pt.roll,
                             want.table_empty, want.overflowed,
                             " / got x=%h y=%h lat=%h roll=%h empty=%b ovf=%b",
                             got.pt.x, got.pt.y, got.pt.lateral, got.pt.roll,
                             got.table_empty, got.overflowed);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   items_sent;

    plpt_cmd_if cmd_ch ();
    plpt_rsp_if rsp_ch ();

    profile_scoreboard sb = new();

    piecewise_linear_profile_table_unit #(
        .TABLE_DEPTH   (DEPTH),
        .FRACTION_BITS (FRAC_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return ($urandom_range(1)) ? 32'sd0 : -32'sd1;
            3:       return 32'(int'($urandom_range(0, 2097152)) - 1048576);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_position();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return POS_ONE;
        if (r < 16)
            return POS_NEG_ONE;
        if (r < 28)
            return 16'($urandom);
        // segment boundaries for power-of-two segment counts
        if (r < 38)
            return 16'(int'($urandom_range(0, 8)) * 4096 - 16384);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic profile_point_t rand_point();
        profile_point_t pt;
        pt.x       = rand_value();
        pt.y       = rand_value();
        pt.lateral = rand_value();
        pt.roll    = rand_value();
        return pt;
    endfunction

    function automatic cmd_item_t make_item(input logic [CMD_W-1:0] command,
                                            input profile_point_t pt,
                                            input logic signed [POS_W-1:0] position);
        cmd_item_t it;
        it.command  = command;
        it.pt       = pt;
        it.position = position;
        return it;
    endfunction

    function automatic profile_point_t fill_point(input logic signed [VALUE_W-1:0] v);
        profile_point_t pt;
        pt.x       = v;
        pt.y       = v;
        pt.lateral = v;
        pt.roll    = v;
        return pt;
    endfunction

    task automatic send_cmd(input cmd_item_t it);
        while (!steady && $urandom_range(99) < 18)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= it.command;
        cmd_ch.point_x       <= it.pt.x;
        cmd_ch.point_y       <= it.pt.y;
        cmd_ch.point_lateral <= it.pt.lateral;
        cmd_ch.point_roll    <= it.pt.roll;
        cmd_ch.position      <= it.position;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        sb.note_command(it);
        if (it.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic hold_until_drained();
        cmd_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_query(input logic signed [POS_W-1:0] position);
        send_cmd(make_item(CMD_QUERY, rand_point(), position));
    endtask

    // response side: random stalls, check every accepted point
    initial
    begin : rsp_side
        query_result_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.pt.x        = rsp_ch.out_x;
                got.pt.y        = rsp_ch.out_y;
                got.pt.lateral  = rsp_ch.out_lateral;
                got.pt.roll     = rsp_ch.out_roll;
                got.table_empty = rsp_ch.table_empty;
                got.overflowed  = rsp_ch.overflowed;
                sb.check_point(got);
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= 18);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int fill;
        int r;
        rst_n                = 1'b0;
        steady               = 1'b0;
        items_sent           = 0;
        phase                = 0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_CLEAR;
        cmd_ch.point_x       = '0;
        cmd_ch.point_y       = '0;
        cmd_ch.point_lateral = '0;
        cmd_ch.point_roll    = '0;
        cmd_ch.position      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, clamped both ways
        send_query(16'sh8000);
        send_query(16'sh7FFF);
        send_query(16'sd0);
        send_cmd(make_item(CMD_UNUSED, rand_point(), rand_position()));
        // single point
        send_cmd(make_item(CMD_APPEND, fill_point(32'sh7FFFFFFF), 16'sd0));
        send_query(16'sd0);
        send_query(16'sh8000);
        // two extreme points: ends, middle, top end
        send_cmd(make_item(CMD_APPEND, fill_point(32'sh80000000), 16'sd0));
        send_query(POS_NEG_ONE);
        send_query(POS_ONE);
        send_query(16'sd0);
        send_query(16'sd1);
        send_query(-16'sd1);
        send_query(16'sd16383);
        send_cmd(make_item(CMD_APPEND, fill_point(32'sd0), 16'sd0));
        send_query(16'sd8192);
        send_query(16'sh7FFF);
        send_cmd(make_item(CMD_CLEAR, rand_point(), rand_position()));
        send_query(16'sd4096);
        send_cmd(make_item(CMD_APPEND, fill_point(-32'sd1), 16'sd0));
        send_query(-16'sd9999);

        while (items_sent < ITEM_TARGET)
        begin
            phase++;
            if (phase == 10 || $urandom_range(99) < 6)
                hold_until_drained();
            if ($urandom_range(99) < 80)
                send_cmd(make_item(CMD_CLEAR, rand_point(), rand_position()));
            // full-table phases only in the second half so the flag is seen low first
            if (items_sent > ITEM_TARGET / 2 && $urandom_range(99) < 10)
                fill = $urandom_range(60, 70);
            else
                fill = $urandom_range(0, 8);
            repeat (fill)
                send_cmd(make_item(CMD_APPEND, rand_point(), rand_position()));
            repeat ($urandom_range(1, 12))
            begin
                r = $urandom_range(99);
                if (r < 4)
                    send_cmd(make_item(CMD_UNUSED, rand_point(), rand_position()));
                else if (r < 9)
                    send_cmd(make_item(CMD_APPEND, rand_point(), rand_position()));
                else if (r < 11)
                    send_cmd(make_item(CMD_CLEAR, rand_point(), rand_position()));
                else
                    send_query(rand_position());
            end
            steady = (items_sent >= 400 && items_sent < 700);
        end
        steady = 1'b0;
        cmd_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/plpt_pkg.sv
hw/rtl/plpt_cmd_if.sv
hw/rtl/plpt_rsp_if.sv
hw/rtl/plpt_lerp_lane.sv
hw/rtl/piecewise_linear_profile_table_unit.sv
dv/tb.sv
